// File: rtl/siar_pkg.sv
// shared types, command codes and constants for the signed alu with round
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package siar_pkg;

    localparam int unsigned W = 64;
    localparam int unsigned MAX_DIGITS = 18;
    localparam int unsigned MUL_HALF = 32;
    // one bit of quotient per divider stage
    localparam int unsigned DIV_STAGES = W;

    typedef enum logic [3:0] {
        CMD_ADD = 4'd0,
        CMD_SUB = 4'd1,
        CMD_MUL = 4'd2,
        CMD_DIV = 4'd3,
        CMD_MOD = 4'd4,
        CMD_NEG = 4'd5,
        CMD_ABS = 4'd6,
        CMD_SGN = 4'd7,
        CMD_RND = 4'd8,
        CMD_MIN = 4'd9,
        CMD_MAX = 4'd10
    } t_cmd;

    typedef struct packed {
        logic [3:0]          command;
        logic signed [W-1:0] left_operand;
        logic signed [W-1:0] right_operand;
    } t_in;

    typedef struct packed {
        logic signed [W-1:0] value;
        logic                numeric_error;
    } t_out;

    // operation decoded in the front stage, carried alongside the divider
    typedef struct packed {
        logic [3:0]   command;
        logic [W-1:0] quick_value;  // result for commands computed in the front stage
        logic         quick_err;
        logic         is_div;       // quotient path used (div, round)
        logic         is_mod;
        logic         is_rnd;
        logic         q_neg;        // negate quotient
        logic         r_neg;        // negate remainder
        logic [W-1:0] divisor;      // magnitude of divisor
    } t_ctl;

    function automatic logic [W-1:0] pow_ten(input logic [4:0] n);
        logic [W-1:0] p;
        p = 64'd1;
        case (n)
            5'd0:  p = 64'd1;
            5'd1:  p = 64'd10;
            5'd2:  p = 64'd100;
            5'd3:  p = 64'd1000;
            5'd4:  p = 64'd10000;
            5'd5:  p = 64'd100000;
            5'd6:  p = 64'd1000000;
            5'd7:  p = 64'd10000000;
            5'd8:  p = 64'd100000000;
            5'd9:  p = 64'd1000000000;
            5'd10: p = 64'd10000000000;
            5'd11: p = 64'd100000000000;
            5'd12: p = 64'd1000000000000;
            5'd13: p = 64'd10000000000000;
            5'd14: p = 64'd100000000000000;
            5'd15: p = 64'd1000000000000000;
            5'd16: p = 64'd10000000000000000;
            5'd17: p = 64'd100000000000000000;
            5'd18: p = 64'd1000000000000000000;
            default: p = 64'd1;
        endcase
        return p;
    endfunction

endpackage
`default_nettype wire

// File: rtl/signed_integer_alu_with_round_unit.sv
// top level of the signed 64-bit alu with decimal round
// depends on siar_pkg, siar_front, siar_mul, siar_div_stage
//
// usage: drive i_item and raise i_start; busy is always low, so one
// transfer may be made in every cycle. each item gives exactly one result,
// shown for one cycle on o_result with o_done high, in input order.
// every command passes one decode stage, 64 divider
// stages (one quotient bit each) and one output stage. throughput is one
// item per cycle; the 64-stage divider chain sets the latency, and the
// multiplier runs alongside it in the first stages.
// reset clears all valid bits; items in flight are dropped.
// the receiver cannot stall and must take each result when o_done is high.
`timescale 1ns / 1ps
`default_nettype none
module signed_integer_alu_with_round_unit (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire siar_pkg::t_in  i_item,
    output logic                o_busy,
    output logic                o_done,
    output siar_pkg::t_out      o_result
);
    localparam int unsigned W = siar_pkg::W;
    localparam int unsigned S = siar_pkg::DIV_STAGES;

    logic           f_valid;
    siar_pkg::t_ctl f_ctl;
    logic [W-1:0]   f_dividend, f_a, f_b, prod;

    logic           v [S+1];
    siar_pkg::t_ctl c [S+1];
    logic [W-1:0]   rem [S+1];
    logic [W-1:0]   quo [S+1];
    logic [W-1:0]   ml  [S+1];

    logic [W-1:0]   q_s, r_s, q_fix, twice;
    logic           round_up;
    siar_pkg::t_out n_res;
    logic           r_done;
    siar_pkg::t_out r_res;

    assign o_busy = 1'b0;

    siar_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_start && !o_busy),
        .i_item(i_item), .o_valid(f_valid), .o_ctl(f_ctl),
        .o_dividend(f_dividend), .o_mul_a(f_a), .o_mul_b(f_b)
    );

    siar_mul u_mul (.i_clk(i_clk), .i_a(f_a), .i_b(f_b), .o_prod(prod));

    assign v[0]   = f_valid;
    assign c[0]   = f_ctl;
    assign rem[0] = '0;
    assign quo[0] = f_dividend;
    assign ml[0]  = '0;

    // divider chain; product joins after the multiplier latency
    for (genvar g = 0; g < S; g++) begin : g_div
        logic [W-1:0] mul_in;
        if (g == 2) begin : g_join
            assign mul_in = prod;
        end else begin : g_pass
            assign mul_in = ml[g];
        end
        siar_div_stage u_stage (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(v[g]), .i_ctl(c[g]),
            .i_rem(rem[g]), .i_quo(quo[g]), .i_mul_lo(mul_in),
            .o_valid(v[g+1]), .o_ctl(c[g+1]), .o_rem(rem[g+1]),
            .o_quo(quo[g+1]), .o_mul_lo(ml[g+1])
        );
    end

    // sign fix-up, rounding and result select
    always_comb begin
        q_s      = c[S].q_neg ? (~quo[S] + 64'd1) : quo[S];
        r_s      = c[S].r_neg ? (~rem[S] + 64'd1) : rem[S];
        twice    = {rem[S][W-2:0], 1'b0};
        round_up = !c[S].r_neg && (twice >= c[S].divisor);
        q_fix    = q_s + {63'd0, c[S].is_rnd && round_up};
        n_res.numeric_error = c[S].quick_err;
        if (c[S].is_div) begin
            n_res.value = q_fix;
        end else if (c[S].is_mod) begin
            n_res.value = r_s;
        end else if (c[S].command == siar_pkg::CMD_MUL) begin
            n_res.value = ml[S];
        end else begin
            n_res.value = c[S].quick_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= v[S];
        end
        r_res <= n_res;
    end

    assign o_done   = r_done;
    assign o_result = r_res;

    // checks
    a_err_only_arith: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        v[S] && n_res.numeric_error |-> (c[S].command == siar_pkg::CMD_MUL ||
        c[S].command == siar_pkg::CMD_DIV || c[S].command == siar_pkg::CMD_MOD))
        else $error("error flag on a command that cannot raise it");
    a_path_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        v[S] |-> !(c[S].is_div && c[S].is_mod))
        else $error("quotient and remainder paths both selected");
    a_rem_lt_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        v[S] && (c[S].is_div || c[S].is_mod) |-> rem[S] < c[S].divisor)
        else $error("divider remainder not below divisor");
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_valid |-> ##(S+1) o_done)
        else $error("result lost in pipeline");
endmodule
`default_nettype wire

// File: rtl/siar_front.sv
// front stage: command decode, quick results, operand magnitudes
// depends on siar_pkg
`timescale 1ns / 1ps
`default_nettype none
module siar_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire siar_pkg::t_in        i_item,
    output logic                      o_valid,
    output siar_pkg::t_ctl            o_ctl,
    output logic [siar_pkg::W-1:0]    o_dividend,
    output logic [siar_pkg::W-1:0]    o_mul_a,
    output logic [siar_pkg::W-1:0]    o_mul_b
);
    localparam int unsigned W = siar_pkg::W;

    logic [W-1:0] a, b, mag_a, mag_b, ten;
    logic         b_zero, b_m1, b_pos, a_neg, b_neg;
    logic [4:0]   n;
    siar_pkg::t_ctl n_ctl;
    logic         r_valid;
    siar_pkg::t_ctl r_ctl;
    logic [W-1:0] r_dividend, r_mul_a, r_mul_b;

    // operand decode
    always_comb begin
        a      = i_item.left_operand;
        b      = i_item.right_operand;
        a_neg  = a[W-1];
        b_neg  = b[W-1];
        mag_a  = a_neg ? (~a + 64'd1) : a;
        mag_b  = b_neg ? (~b + 64'd1) : b;
        b_zero = (b == '0);
        b_m1   = (b == '1);
        b_pos  = !b_neg && !b_zero;
        n      = (b_pos && (b < 64'(siar_pkg::MAX_DIGITS))) ? b[4:0]
                                                             : 5'(siar_pkg::MAX_DIGITS);
        ten    = siar_pkg::pow_ten(n);
    end

    // per-command result and divider setup
    always_comb begin
        n_ctl             = '0;
        n_ctl.command     = i_item.command;
        n_ctl.divisor     = mag_b;
        n_ctl.q_neg       = a_neg ^ b_neg;
        n_ctl.r_neg       = a_neg;
        case (i_item.command)
            siar_pkg::CMD_ADD: n_ctl.quick_value = a + b;
            siar_pkg::CMD_SUB: n_ctl.quick_value = a - b;
            siar_pkg::CMD_MUL: n_ctl.quick_err =
                (mag_a >= 64'h1000000) && (mag_b >= 64'h1000000);
            siar_pkg::CMD_DIV: begin
                if (b_zero) begin
                    n_ctl.quick_err = 1'b1;
                end else if (b_m1) begin
                    n_ctl.quick_value = ~a + 64'd1;
                end else begin
                    n_ctl.is_div = 1'b1;
                end
            end
            siar_pkg::CMD_MOD: begin
                if (b_zero) begin
                    n_ctl.quick_err   = 1'b1;
                    n_ctl.quick_value = a;
                end else if (!b_m1) begin
                    n_ctl.is_mod = 1'b1;
                end
            end
            siar_pkg::CMD_NEG: n_ctl.quick_value = ~a + 64'd1;
            siar_pkg::CMD_ABS: n_ctl.quick_value = mag_a;
            siar_pkg::CMD_SGN: n_ctl.quick_value = a_neg ? '1 : (a == '0 ? '0 : 64'd1);
            siar_pkg::CMD_RND: begin
                if (b_pos) begin
                    n_ctl.is_div  = 1'b1;
                    n_ctl.is_rnd  = 1'b1;
                    n_ctl.divisor = ten;
                    n_ctl.q_neg   = a_neg;
                end else begin
                    n_ctl.quick_value = a;
                end
            end
            siar_pkg::CMD_MIN: n_ctl.quick_value = ($signed(a) < $signed(b)) ? a : b;
            siar_pkg::CMD_MAX: n_ctl.quick_value = ($signed(a) > $signed(b)) ? a : b;
            default: n_ctl.quick_value = '0;
        endcase
    end

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_ctl      <= n_ctl;
        r_dividend <= mag_a;
        r_mul_a    <= a;
        r_mul_b    <= b;
    end

    assign o_valid    = r_valid;
    assign o_ctl      = r_ctl;
    assign o_dividend = r_dividend;
    assign o_mul_a    = r_mul_a;
    assign o_mul_b    = r_mul_b;
endmodule
`default_nettype wire

// File: rtl/siar_div_stage.sv
// one restoring divider step: one quotient bit per stage
// depends on siar_pkg
`timescale 1ns / 1ps
`default_nettype none
module siar_div_stage (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire siar_pkg::t_ctl       i_ctl,
    input  wire logic [siar_pkg::W-1:0] i_rem,
    input  wire logic [siar_pkg::W-1:0] i_quo,
    input  wire logic [siar_pkg::W-1:0] i_mul_lo,
    output logic                      o_valid,
    output siar_pkg::t_ctl            o_ctl,
    output logic [siar_pkg::W-1:0]    o_rem,
    output logic [siar_pkg::W-1:0]    o_quo,
    output logic [siar_pkg::W-1:0]    o_mul_lo
);
    localparam int unsigned W = siar_pkg::W;

    logic [W:0]   shifted, diff;
    logic [W-1:0] n_rem, n_quo;
    logic         r_valid;
    siar_pkg::t_ctl r_ctl;
    logic [W-1:0] r_rem, r_quo, r_mul_lo;

    // shift in next dividend bit, trial subtract
    always_comb begin
        shifted = {i_rem, i_quo[W-1]};
        diff    = shifted - {1'b0, i_ctl.divisor};
        if (!diff[W]) begin
            n_rem = diff[W-1:0];
            n_quo = {i_quo[W-2:0], 1'b1};
        end else begin
            n_rem = shifted[W-1:0];
            n_quo = {i_quo[W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_ctl    <= i_ctl;
        r_rem    <= n_rem;
        r_quo    <= n_quo;
        r_mul_lo <= i_mul_lo;
    end

    assign o_valid  = r_valid;
    assign o_ctl    = r_ctl;
    assign o_rem    = r_rem;
    assign o_quo    = r_quo;
    assign o_mul_lo = r_mul_lo;
endmodule
`default_nettype wire

// File: rtl/siar_mul.sv
// two-stage 64-bit low-half multiplier from 32x32 partial products
// depends on siar_pkg
`timescale 1ns / 1ps
`default_nettype none
module siar_mul (
    input  wire logic                   i_clk,
    input  wire logic [siar_pkg::W-1:0] i_a,
    input  wire logic [siar_pkg::W-1:0] i_b,
    output logic [siar_pkg::W-1:0]      o_prod
);
    localparam int unsigned W = siar_pkg::W;
    localparam int unsigned H = siar_pkg::MUL_HALF;

    logic [W-1:0] r_ll, r_lh, r_hl, r_sum;

    // partial products, then cross terms folded into the upper half
    always_ff @(posedge i_clk) begin
        r_ll  <= W'(i_a[H-1:0]) * W'(i_b[H-1:0]);
        r_lh  <= W'(i_a[H-1:0] * i_b[W-1:H]);
        r_hl  <= W'(i_a[W-1:H] * i_b[H-1:0]);
        r_sum <= r_ll + {r_lh[H-1:0] + r_hl[H-1:0], {H{1'b0}}};
    end

    assign o_prod = r_sum;
endmodule
`default_nettype wire

// File: sim/signed_integer_alu_with_round_unit_tb.sv
// testbench for the signed 64-bit alu with decimal round
// depends on siar_pkg and signed_integer_alu_with_round_unit
`timescale 1ns / 1ps

// predicts alu results and keeps them in input order
class alu_scoreboard;
    siar_pkg::t_out pending_q[$];
    int unsigned    fail_count;
    int unsigned    result_count;

    function automatic logic [63:0] mag64(logic [63:0] u);
        return u[63] ? (64'd0 - u) : u;
    endfunction

    function automatic logic [63:0] ten_pow(int n);
        logic [63:0] p;
        p = 64'd1;
        for (int k = 0; k < n; k++) p = p * 64'd10;
        return p;
    endfunction

    function automatic siar_pkg::t_out alu_predict(siar_pkg::t_in it);
        siar_pkg::t_out   r;
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic signed [63:0] ten;
        logic signed [63:0] quo;
        logic signed [63:0] rem;
        int                 n;
        a = it.left_operand;
        b = it.right_operand;
        r.value = '0;
        r.numeric_error = 1'b0;
        case (siar_pkg::t_cmd'(it.command))
            siar_pkg::CMD_ADD: r.value = a + b;
            siar_pkg::CMD_SUB: r.value = a - b;
            siar_pkg::CMD_MUL: begin
                r.numeric_error = (mag64(a) >= 64'h1000000) && (mag64(b) >= 64'h1000000);
                r.value = a * b;
            end
            siar_pkg::CMD_DIV: begin
                if (b == 0) r.numeric_error = 1'b1;
                else if (b == -1) r.value = 64'd0 - a;
                else r.value = a / b;
            end
            siar_pkg::CMD_MOD: begin
                if (b == 0) begin
                    r.numeric_error = 1'b1;
                    r.value = a;
                end else if (b == -1) r.value = 0;
                else r.value = a % b;
            end
            siar_pkg::CMD_NEG: r.value = 64'd0 - a;
            siar_pkg::CMD_ABS: r.value = mag64(a);
            siar_pkg::CMD_SGN: r.value = (a < 0) ? -64'sd1 : ((a > 0) ? 64'sd1 : 64'sd0);
            siar_pkg::CMD_RND: begin
                if (b > 0) begin
                    n = (b > 18) ? 18 : int'(b);
                    ten = ten_pow(n);
                    quo = a / ten;
                    rem = a % ten;
                    if (rem * 2 >= ten) quo = quo + 1;
                    r.value = quo;
                end else r.value = a;
            end
            siar_pkg::CMD_MIN: r.value = (a < b) ? a : b;
            siar_pkg::CMD_MAX: r.value = (a > b) ? a : b;
            default: r.value = '0;
        endcase
        return r;
    endfunction

    function void note_input(siar_pkg::t_in it);
        pending_q.push_back(alu_predict(it));
    endfunction

    function void check_result(siar_pkg::t_out got);
        siar_pkg::t_out want;
        result_count++;
        if (pending_q.size() == 0) begin
            $error("result with nothing pending: value %h", got.value);
            fail_count++;
            return;
        end
        want = pending_q.pop_front();
        if (got.value !== want.value) begin
            $error("value: expected %h, actual %h", want.value, got.value);
            fail_count++;
        end
        if (got.numeric_error !== want.numeric_error) begin
            $error("numeric_error: expected %b, actual %b",
                   want.numeric_error, got.numeric_error);
            fail_count++;
        end
    endfunction
endclass

module signed_integer_alu_with_round_unit_tb;

    localparam int N_RANDOM  = 830;
    localparam int LATENCY   = 66;
    localparam int MAX_CYCLE = 200000;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_start;
    siar_pkg::t_in   i_item;
    logic            o_busy;
    logic            o_done;
    siar_pkg::t_out  o_result;

    alu_scoreboard   sb;
    int unsigned     cycle_count;
    int unsigned     sent_count;
    siar_pkg::t_in   directed_q[$];

    signed_integer_alu_with_round_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_item(i_item),
        .o_busy(o_busy), .o_done(o_done), .o_result(o_result)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // result check and timeout
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_done) sb.check_result(o_result);
        if (cycle_count > MAX_CYCLE) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // operand with bias toward edge values
    function automatic logic [63:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 64'h8000000000000000;
            1: return 64'h7fffffffffffffff;
            2: return 64'd0 - 64'($urandom_range(0, 2));
            3: return 64'($urandom_range(0, 40));
            4: return {{40{$urandom_range(0, 1) == 1}}, 24'($urandom)};
            5: return {{32{$urandom_range(0, 1) == 1}}, 32'($urandom)};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic siar_pkg::t_in random_item(bit allow_unused);
        siar_pkg::t_in it;
        it.command = allow_unused ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 10));
        it.left_operand  = pick_operand();
        it.right_operand = pick_operand();
        if (it.command == siar_pkg::CMD_RND && $urandom_range(0, 3) != 0)
            it.right_operand = 64'($urandom_range(0, 22)) - 64'd2;
        return it;
    endfunction

    // one transfer, with an optional random gap before it
    task automatic send_item(siar_pkg::t_in it, bit may_idle);
        int gap;
        if (may_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 16);
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_item  <= it;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        sb.note_input(it);
        sent_count++;
    endtask

    function automatic siar_pkg::t_in mk(siar_pkg::t_cmd c, logic [63:0] a,
                                         logic [63:0] b);
        siar_pkg::t_in it;
        it.command = c;
        it.left_operand = a;
        it.right_operand = b;
        return it;
    endfunction

    initial begin
        int wait_count;
        logic [63:0] most_neg;
        logic [63:0] most_pos;
        siar_pkg::t_in unused_cmd;
        sb = new();
        cycle_count = 0;
        sent_count = 0;
        most_neg = 64'h8000000000000000;
        most_pos = 64'h7fffffffffffffff;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_item  = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed items: every command and the named corner cases
        directed_q.push_back(mk(siar_pkg::CMD_ADD, most_pos, 64'd1));
        directed_q.push_back(mk(siar_pkg::CMD_SUB, most_neg, 64'd1));
        directed_q.push_back(mk(siar_pkg::CMD_MUL, 64'h1000000, 64'hffffffffff000000));
        directed_q.push_back(mk(siar_pkg::CMD_MUL, 64'hffffff, most_neg));
        directed_q.push_back(mk(siar_pkg::CMD_MUL, most_neg, most_neg));
        directed_q.push_back(mk(siar_pkg::CMD_DIV, 64'd7, 64'd0));
        directed_q.push_back(mk(siar_pkg::CMD_DIV, most_neg, 64'hffffffffffffffff));
        directed_q.push_back(mk(siar_pkg::CMD_DIV, 64'hfffffffffffffff9, 64'd2));
        directed_q.push_back(mk(siar_pkg::CMD_MOD, 64'hfffffffffffffff9, 64'd0));
        directed_q.push_back(mk(siar_pkg::CMD_MOD, most_neg, 64'hffffffffffffffff));
        directed_q.push_back(mk(siar_pkg::CMD_MOD, 64'hfffffffffffffff9, 64'd2));
        directed_q.push_back(mk(siar_pkg::CMD_NEG, most_neg, 64'd0));
        directed_q.push_back(mk(siar_pkg::CMD_ABS, most_neg, 64'd0));
        directed_q.push_back(mk(siar_pkg::CMD_ABS, 64'hfffffffffffffffe, 64'd0));
        directed_q.push_back(mk(siar_pkg::CMD_SGN, most_neg, 64'd0));
        directed_q.push_back(mk(siar_pkg::CMD_SGN, 64'd0, 64'd0));
        directed_q.push_back(mk(siar_pkg::CMD_SGN, most_pos, 64'd0));
        directed_q.push_back(mk(siar_pkg::CMD_RND, 64'd12345, 64'd0));
        directed_q.push_back(mk(siar_pkg::CMD_RND, 64'd12350, 64'd2));
        directed_q.push_back(mk(siar_pkg::CMD_RND, most_pos, 64'd40));
        directed_q.push_back(mk(siar_pkg::CMD_RND, 64'hffffffffffffcfc7, 64'd2));
        directed_q.push_back(mk(siar_pkg::CMD_RND, most_neg, most_pos));
        directed_q.push_back(mk(siar_pkg::CMD_MIN, most_neg, most_pos));
        directed_q.push_back(mk(siar_pkg::CMD_MAX, most_neg, most_pos));
        unused_cmd = mk(siar_pkg::CMD_ADD, 64'd5, 64'd6);
        unused_cmd.command = 4'd15;
        directed_q.push_back(unused_cmd);
        foreach (directed_q[k]) send_item(directed_q[k], 1'b0);

        // random items, gaps only in the first part
        for (int k = 0; k < N_RANDOM; k++)
            send_item(random_item($urandom_range(0, 19) == 0), k < N_RANDOM - 150);
        i_start <= 1'b0;

        // drain
        wait_count = 0;
        while (sb.pending_q.size() != 0 && wait_count < 20 * LATENCY) begin
            @(posedge i_clk);
            wait_count++;
        end
        repeat (LATENCY + 4) @(posedge i_clk);

        $display("sent %0d items over all commands, checked %0d results",
                 sent_count, sb.result_count);
        if (sb.pending_q.size() != 0) begin
            $error("%0d results never arrived", sb.pending_q.size());
            sb.fail_count++;
        end
        if (sb.fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
